>>> hdl/quadratic_probe_hash_set_defines.svh
// Assertion macros shared by the hash set RTL.
// Each macro expects clk and arst_n in the scope of its use.
`ifndef QUADRATIC_PROBE_HASH_SET_DEFINES_SVH
`define QUADRATIC_PROBE_HASH_SET_DEFINES_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on the rising clock edge.
`define QPHS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define QPHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define QPHS_ASSERT_IMPL(lbl, ante, cons, msg)
`define QPHS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/qphs_pkg.sv
package qphs_pkg;

	localparam int KEY_W    = 32;
	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 10;
	localparam int COUNT_W  = 11;
	localparam int CFG_W    = 11;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_MAX_PROBES  = 16;

	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

	// Remainder unit: two quotient bits per cycle
	localparam int DIV_BITS  = 2;
	localparam int DIV_ITERS = KEY_W / DIV_BITS;
	localparam int DIV_CW    = $clog2(DIV_ITERS);

	typedef enum logic [KIND_W-1:0] {
		KIND_INSERT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_FIND   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_CHECK,
		ST_RESULT
	} step_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_CLEAR,
		ACT_ACCEPT,
		ACT_PROBE_INIT,
		ACT_READ,
		ACT_CHECK
	} act_t;

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_CLEAR_END,
		COND_START,
		COND_DIV_DONE,
		COND_PROBE_END
	} cond_t;

	typedef struct packed {
		logic  busy;
		logic  strobe;
		act_t  act;
		cond_t cond;
		step_t on_true;
		step_t on_false;
	} ucode_t;

	// Control store: one word per step
	function automatic ucode_t ucode_rom(input step_t s);
		ucode_t w;
		case (s)
			ST_CLEAR:  w = '{1'b1, 1'b0, ACT_CLEAR,      COND_CLEAR_END, ST_IDLE,   ST_CLEAR};
			ST_IDLE:   w = '{1'b0, 1'b0, ACT_ACCEPT,     COND_START,     ST_DIV,    ST_IDLE};
			ST_DIV:    w = '{1'b1, 1'b0, ACT_PROBE_INIT, COND_DIV_DONE,  ST_READ,   ST_DIV};
			ST_READ:   w = '{1'b1, 1'b0, ACT_READ,       COND_ALWAYS,    ST_CHECK,  ST_CHECK};
			ST_CHECK:  w = '{1'b1, 1'b0, ACT_CHECK,      COND_PROBE_END, ST_RESULT, ST_READ};
			ST_RESULT: w = '{1'b1, 1'b1, ACT_NONE,       COND_ALWAYS,    ST_IDLE,   ST_IDLE};
			default:   w = '{1'b1, 1'b0, ACT_NONE,       COND_ALWAYS,    ST_IDLE,   ST_IDLE};
		endcase
		return w;
	endfunction

endpackage

>>> hdl/qphs_mod.sv
// Remainder of a key by the bucket count, restoring, two bits per cycle.
module qphs_mod import qphs_pkg::*; #(
	parameter int NW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [KEY_W-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic          done,
	output logic [NW-1:0] rem
);

	logic              run_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [KEY_W-1:0]  q_q;
	logic [NW-1:0]     r_q;
	logic [NW-1:0]     d_q;
	logic [NW:0]       r_w;
	logic [KEY_W-1:0]  q_w;

	always_comb begin
		r_w = {1'b0, r_q};
		q_w = q_q;
		for (int j = 0; j < DIV_BITS; j++) begin
			r_w = {r_w[NW-1:0], q_w[KEY_W-1]};
			q_w = {q_w[KEY_W-2:0], 1'b0};
			if (r_w >= {1'b0, d_q}) begin
				r_w = r_w - {1'b0, d_q};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + DIV_CW'(1);
				if (cnt_q == DIV_CW'(DIV_ITERS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= '0;
			d_q <= divisor;
		end else if (run_q) begin
			q_q <= q_w;
			r_q <= r_w[NW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

>>> hdl/quadratic_probe_hash_set.sv
// Open-addressing hash set of 32-bit unsigned keys with quadratic probing.
// Start an operation by raising start with kind (insert, delete, find) and key;
// the beat is taken at a clock edge where start is high and busy is low. Each
// operation returns exactly one result, shown on success, slot and
// element_count for a single cycle while done is high. The receiver cannot
// stall: capture the result in that cycle, as done is high only then.
// An operation first computes the key mod table_size remainder (two bits per
// cycle), then walks 1 to MAX_PROBES probes; busy stays high from the accepted
// beat through the result, so one operation runs at a time. Each probe takes a
// read step and a check step, because the bucket memory has a registered read
// port whose data decides whether the walk goes on.
// After reset the block sweeps the bucket memory once, one bucket per cycle,
// clearing every occupied mark: busy stays high until the sweep is over, and
// no beat is taken before. table_size may be written at any time over the
// cfg channel (always ready) but must only change while the block is idle.
// A table_size of zero acts as one, and a value above TABLE_DEPTH acts as
// TABLE_DEPTH. Shrinking it hides buckets beyond the new size without
// emptying them; they stay in the element count.
// Control is a microcoded sequencer: a small control store in qphs_pkg gives
// per step the action on the datapath and a conditional jump.
`include "quadratic_probe_hash_set_defines.svh"

module quadratic_probe_hash_set import qphs_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int MAX_PROBES  = DEF_MAX_PROBES
) (
	input  logic               clk,
	input  logic               arst_n,
	// command channel
	input  logic               start,
	output logic               busy,
	input  logic [KIND_W-1:0]  kind,
	input  logic [KEY_W-1:0]   key,
	// result strobe
	output logic               done,
	output logic               success,
	output logic [SLOT_W-1:0]  slot,
	output logic [COUNT_W-1:0] element_count,
	// table_size register
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   cfg_data
);

	localparam int AW = $clog2(TABLE_DEPTH);      // bucket address
	localparam int NW = $clog2(TABLE_DEPTH + 1);  // bucket count, probe arithmetic
	localparam int CW = $clog2(TABLE_DEPTH + 1);  // occupied bucket count
	localparam int PW = $clog2(MAX_PROBES + 1);   // probe index
	localparam int SW = NW + 1;                   // sum of two values below n
	localparam int TW = NW + 2;                   // step term plus two
	localparam int MW = KEY_W + 1;                // memory word: occupied mark and key

	// Sequencer
	step_t  step_q;
	step_t  step_d;
	ucode_t uc;
	logic   cond_met;

	// Datapath registers
	logic [CFG_W-1:0]  table_size_q;
	logic [KIND_W-1:0] kind_q;
	logic [KEY_W-1:0]  key_q;
	logic [NW-1:0]     n_q;
	logic [NW-1:0]     pos_q;
	logic [NW-1:0]     dlt_q;
	logic [PW-1:0]     prb_q;
	logic [AW-1:0]     clr_q;
	logic [MW-1:0]     rd_q;
	logic              success_q;
	logic [AW-1:0]     where_q;
	logic [CW-1:0]     count_q;

	// Bucket memory
	logic [MW-1:0] mem [TABLE_DEPTH];
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	logic [MW-1:0] mem_wd;

	// Remainder unit
	logic          div_start;
	logic          div_done;
	logic [NW-1:0] div_rem;

	// Combinational helpers
	logic          accept;
	logic [31:0]   ts_ext;
	logic [31:0]   n_full;
	logic [NW-1:0] n_c;
	logic          clear_end;
	logic          occ;
	logic          hit;
	logic          is_ins;
	logic          is_del;
	logic          is_find;
	logic          kind_ok;
	logic          last_probe;
	logic          take_slot;
	logic          probe_end;
	logic [SW-1:0] pos_sum;
	logic [NW-1:0] pos_nx;
	logic [TW-1:0] dlt_t1;
	logic [TW-1:0] dlt_t2;
	logic [TW-1:0] dlt_t3;
	logic [NW-1:0] dlt_nx;

	qphs_mod #(
		.NW(NW)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(key),
		.divisor (n_c),
		.done    (div_done),
		.rem     (div_rem)
	);

	// ---------------------------------------------------------------- control store
	assign uc = ucode_rom(step_q);

	assign accept    = (uc.act == ACT_ACCEPT) && start;
	assign div_start = accept;
	assign clear_end = (clr_q == AW'(TABLE_DEPTH - 1));

	// Clamp table_size into 1..TABLE_DEPTH
	assign ts_ext = 32'(table_size_q);
	assign n_full = (ts_ext == 32'd0) ? 32'd1 :
		((ts_ext > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : ts_ext);
	assign n_c    = NW'(n_full);

	// ---------------------------------------------------------------- probe decision
	assign occ        = rd_q[MW-1];
	assign hit        = occ && (rd_q[KEY_W-1:0] == key_q);
	assign is_ins     = (kind_q == KIND_INSERT);
	assign is_del     = (kind_q == KIND_DELETE);
	assign is_find    = (kind_q == KIND_FIND);
	assign kind_ok    = is_ins || is_del || is_find;
	assign last_probe = (prb_q == PW'(MAX_PROBES - 1));
	assign take_slot  = is_ins ? !occ : ((is_del || is_find) && hit);
	assign probe_end  = !kind_ok || take_slot || (is_ins && hit) || last_probe;

	// Next probe: pos += (2i+1) mod n, then step term += 2 mod n
	always_comb begin
		pos_sum = {1'b0, pos_q} + {1'b0, dlt_q};
		if (pos_sum >= {1'b0, n_q}) begin
			pos_nx = NW'(pos_sum - {1'b0, n_q});
		end else begin
			pos_nx = NW'(pos_sum);
		end
		dlt_t1 = {2'b00, dlt_q} + TW'(2);
		dlt_t2 = (dlt_t1 >= {2'b00, n_q}) ? dlt_t1 - {2'b00, n_q} : dlt_t1;
		dlt_t3 = (dlt_t2 >= {2'b00, n_q}) ? dlt_t2 - {2'b00, n_q} : dlt_t2;
		dlt_nx = NW'(dlt_t3);
	end

	// ---------------------------------------------------------------- next step
	always_comb begin
		case (uc.cond)
			COND_ALWAYS:    cond_met = 1'b1;
			COND_CLEAR_END: cond_met = clear_end;
			COND_START:     cond_met = start;
			COND_DIV_DONE:  cond_met = div_done;
			COND_PROBE_END: cond_met = probe_end;
			default:        cond_met = 1'b1;
		endcase
		step_d = cond_met ? uc.on_true : uc.on_false;
	end

	// ---------------------------------------------------------------- control outputs
	always_comb begin
		mem_we = 1'b0;
		mem_wa = clr_q;
		mem_wd = '0;
		case (uc.act)
			ACT_CLEAR: begin
				mem_we = 1'b1;
			end
			ACT_CHECK: begin
				// insert marks the bucket, delete drops the mark
				mem_wa = pos_q[AW-1:0];
				if (is_ins && !occ) begin
					mem_we = 1'b1;
					mem_wd = {1'b1, key_q};
				end else if (is_del && hit) begin
					mem_we = 1'b1;
					mem_wd = {1'b0, key_q};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// ---------------------------------------------------------------- control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= ST_CLEAR;
			table_size_q <= CFG_RESET;
			clr_q        <= '0;
			count_q      <= '0;
			success_q    <= 1'b0;
		end else begin
			step_q <= step_d;
			if (cfg_valid && cfg_ready) begin
				table_size_q <= cfg_data;
			end
			if (uc.act == ACT_CLEAR && !clear_end) begin
				clr_q <= clr_q + AW'(1);
			end
			if (accept) begin
				success_q <= 1'b0;
			end
			if (uc.act == ACT_CHECK && take_slot) begin
				success_q <= 1'b1;
				if (is_ins) begin
					count_q <= count_q + CW'(1);
				end else if (is_del && count_q != '0) begin
					count_q <= count_q - CW'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------- payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind;
			key_q   <= key;
			n_q     <= n_c;
			where_q <= '0;
		end
		case (uc.act)
			ACT_PROBE_INIT: begin
				// load every cycle; the last load carries the finished remainder
				pos_q <= div_rem;
				dlt_q <= (n_q == NW'(1)) ? '0 : NW'(1);
				prb_q <= '0;
			end
			ACT_CHECK: begin
				if (take_slot) begin
					where_q <= pos_q[AW-1:0];
				end
				if (!probe_end) begin
					pos_q <= pos_nx;
					dlt_q <= dlt_nx;
					prb_q <= prb_q + PW'(1);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

	// Bucket memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (uc.act == ACT_READ) begin
			rd_q <= mem[pos_q[AW-1:0]];
		end
	end

	// ---------------------------------------------------------------- ports
	assign busy          = uc.busy;
	assign done          = uc.strobe;
	assign cfg_ready     = 1'b1;
	assign success       = success_q;
	assign slot          = SLOT_W'(where_q);
	assign element_count = COUNT_W'(count_q);

	// ---------------------------------------------------------------- assertions
	`QPHS_ASSERT_NEXT(a_start_takes, start && !busy, busy && !done, "beat did not start work")
	`QPHS_ASSERT_NEXT(a_done_frees, done, !busy, "block stayed busy after the result beat")
	`QPHS_ASSERT_IMPL(a_fail_slot, done && !success, slot == '0, "failed result has a slot")
	`QPHS_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(TABLE_DEPTH), "count above depth")

endmodule
